### design/imu_packet_deframer_macros.svh
// Assertion macros for the IMU packet deframer checker.
// Used by imu_packet_deframer_checker.sv only; no other dependencies.
`ifndef IMU_PACKET_DEFRAMER_MACROS_SVH
`define IMU_PACKET_DEFRAMER_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define IPD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("imu_packet_deframer assertion failed");

// Clocked assertion that is also checked through reset.
`define IPD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("imu_packet_deframer assertion failed");

`endif

### design/ipd_pkg.sv
// Shared types and constants for the IMU packet deframer.
// No dependencies; imported by ipd_byte_cell, ipd_sum_pipe and the top level.
package ipd_pkg;

    localparam int unsigned WinLen  = 22;   // bytes held in the window
    localparam int unsigned NWords  = 10;   // data words per packet
    localparam int unsigned FillW   = 5;
    localparam int unsigned IdxYaw  = 2;    // yaw word position

    localparam logic [7:0]  HdrByte   = 8'h31;
    localparam logic [15:0] DeclReset = 16'hFA6B;   // -1429 counts

    typedef logic [7:0] t_byte;
    typedef logic [NWords-1:0][15:0] t_words;

    typedef struct packed {
        t_words      words;
        logic [15:0] chk;
    } t_pkt;

endpackage

### design/ipd_byte_cell.sv
// One cell of the byte window: holds a byte and takes its neighbor's byte on a shift.
// Depends on ipd_pkg.
module ipd_byte_cell (
    input  logic          i_clk,
    input  logic          i_shift,
    input  ipd_pkg::t_byte i_byte,
    output ipd_pkg::t_byte o_byte
);
    import ipd_pkg::*;

    t_byte r_byte;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

### design/ipd_sum_pipe.sv
// Three-stage packet pipeline: capture, partial sums and yaw offset, final sum and compare.
// Depends on ipd_pkg. Output stage is the master-side word register.
module ipd_sum_pipe (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  ipd_pkg::t_pkt   i_pkt,
    input  logic [15:0]     i_declination,
    output logic            o_valid,
    input  logic            i_ready,
    output ipd_pkg::t_words o_words,
    output logic            o_ok
);
    import ipd_pkg::*;

    logic        r_a_v, r_b_v, r_c_v;
    logic        w_rdy_a, w_rdy_b, w_rdy_c;
    t_pkt        r_a_pkt;
    t_words      r_b_words, r_c_words;
    t_words      w_b_words;
    logic [15:0] r_b_chk;
    logic [3:0][15:0] r_b_part;
    logic [15:0] w_total;
    logic        r_c_ok;

    assign w_rdy_c = !r_c_v || i_ready;
    assign w_rdy_b = !r_b_v || w_rdy_c;
    assign w_rdy_a = !r_a_v || w_rdy_b;
    assign o_ready = w_rdy_a;

    // header byte is always 0x31 when a packet is captured
    assign w_total = r_b_part[0] + r_b_part[1] + r_b_part[2] + r_b_part[3];

    always_comb begin
        w_b_words         = r_a_pkt.words;
        w_b_words[IdxYaw] = r_a_pkt.words[IdxYaw] + i_declination;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else begin
            if (w_rdy_a) begin
                r_a_v <= i_valid;
            end
            if (w_rdy_b) begin
                r_b_v <= r_a_v;
            end
            if (w_rdy_c) begin
                r_c_v <= r_b_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_a && i_valid) begin
            r_a_pkt <= i_pkt;
        end
        if (w_rdy_b && r_a_v) begin
            r_b_words   <= w_b_words;
            r_b_chk     <= r_a_pkt.chk;
            r_b_part[0] <= {8'h00, HdrByte} + r_a_pkt.words[0] + r_a_pkt.words[1];
            r_b_part[1] <= r_a_pkt.words[2] + r_a_pkt.words[3] + r_a_pkt.words[4];
            r_b_part[2] <= r_a_pkt.words[5] + r_a_pkt.words[6] + r_a_pkt.words[7];
            r_b_part[3] <= r_a_pkt.words[8] + r_a_pkt.words[9];
        end
        if (w_rdy_c && r_b_v) begin
            r_c_words <= r_b_words;
            r_c_ok    <= (w_total == r_b_chk);
        end
    end

    assign o_valid = r_c_v;
    assign o_words = r_c_words;
    assign o_ok    = r_c_ok;

endmodule

### design/imu_packet_deframer.sv
// Channel   Dir  Word                          Side band
// s_axis    in   tdata[7:0] = byte_in          -
// m_axis    out  tdata[159:0] = 10 x 16 bits   tuser = checksum_ok
// cfg       in   i_cfg_wdata = declination     write on i_cfg_we
//
// One byte is taken per cycle while s_axis_tready is high; the 22-cell shift window
// moves on every accepted byte. A packet result leaves through a 3-stage sum pipeline.
// Synchronous active-low reset empties the window (fill count 0) and the pipeline,
// and loads declination with -1429. The window bytes themselves are not cleared.
// s_axis_tready drops only when all three pipeline stages hold a result and m_axis stalls.
// Depends on ipd_pkg, ipd_byte_cell, ipd_sum_pipe.
module imu_packet_deframer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] byte_in
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // roll, pitch, yaw_heading, roll_accel, pitch_accel, yaw_accel,
    // roll_rate, pitch_rate, yaw_rate, timer_ticks; 16 bits each from bit 0 up
    output logic [159:0] m_axis_tdata,
    output logic         m_axis_tuser,   // [0] checksum_ok
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_wdata     // declination
);
    import ipd_pkg::*;

    logic [WinLen-1:0][7:0] w_win;
    logic                   w_accept, w_full, w_hit;
    logic [FillW-1:0]       r_fill, n_fill;
    logic [15:0]            r_decl;
    t_pkt                   w_pkt;
    t_words                 w_words;

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_full   = (r_fill >= FillW'(WinLen));
    assign w_hit    = w_accept && w_full && (w_win[0] == HdrByte);

    // Oldest byte sits in cell 0; new bytes enter at the far end.
    for (genvar k = 0; k < WinLen; k++) begin : g_cell
        if (k == WinLen - 1) begin : g_tail
            ipd_byte_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_accept),
                .i_byte  (s_axis_tdata),
                .o_byte  (w_win[k])
            );
        end else begin : g_body
            ipd_byte_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_accept),
                .i_byte  (w_win[k+1]),
                .o_byte  (w_win[k])
            );
        end
    end

    for (genvar i = 0; i < NWords; i++) begin : g_word
        assign w_pkt.words[i] = {w_win[1 + 2*i], w_win[2 + 2*i]};
    end
    assign w_pkt.chk = {w_win[WinLen-1], s_axis_tdata};

    always_comb begin
        n_fill = r_fill;
        if (w_accept) begin
            priority if (!w_full) begin
                n_fill = r_fill + FillW'(1);
            end else if (w_hit) begin
                n_fill = '0;
            end else begin
                n_fill = FillW'(WinLen);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_decl <= DeclReset;
        end else begin
            r_fill <= n_fill;
            if (i_cfg_we) begin
                r_decl <= i_cfg_wdata;
            end
        end
    end

    ipd_sum_pipe u_sum (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_hit),
        .o_ready       (s_axis_tready),
        .i_pkt         (w_pkt),
        .i_declination (r_decl),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_words       (w_words),
        .o_ok          (m_axis_tuser)
    );

    assign m_axis_tdata = w_words;

endmodule

### design/imu_packet_deframer_checker.sv
// Port-level checks for imu_packet_deframer, bound to the top level.
// Depends on imu_packet_deframer_macros.svh.
`include "imu_packet_deframer_macros.svh"

module imu_packet_deframer_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [159:0] m_axis_tdata,
    input logic         m_axis_tuser
);

    logic         w_out_stall;
    logic [160:0] w_out_word;

    assign w_out_stall = m_axis_tvalid && !m_axis_tready;
    assign w_out_word  = {m_axis_tuser, m_axis_tdata};

    // a stalled output word holds
    `IPD_ASSERT(a_out_hold, i_clk, i_rst_n, w_out_stall |=> m_axis_tvalid && $stable(w_out_word))

    // the input only backs up behind a stalled output word
    `IPD_ASSERT(a_in_ready, i_clk, i_rst_n, (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)

    // reset empties the output stage
    `IPD_ASSERT_ALWAYS(a_rst_clear, i_clk, !i_rst_n |=> !m_axis_tvalid)

endmodule

bind imu_packet_deframer imu_packet_deframer_checker u_chk (.*);
